### rtl/smm_pkg.sv
// shared types, codes and helpers for the sparse matrix multiplier
package smm_pkg;

  localparam int DIM_W = 4;
  localparam int IDX_W = 3;
  localparam int VAL_W = 32;
  localparam int ACC_W = 64;

  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [1:0] REG_ROWS_OF_A  = 2'd0;
  localparam logic [1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [1:0] REG_COLS_OF_B  = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IDX_W-1:0] entry_row;
    logic [IDX_W-1:0] entry_col;
    logic [VAL_W-1:0] entry_value;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic [ACC_W-1:0] out_value;
    logic             found;
    logic             is_last;
  } result_t;

  // zero counts as one, anything above the array size as the array size
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/smm_cell.sv
// one column cell: multiply, accumulate, and shift toward the output end
module smm_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     mul_en,
  input  logic                     add_en,
  input  logic                     shift_en,
  input  logic [smm_pkg::VAL_W-1:0] a,
  input  logic [smm_pkg::VAL_W-1:0] b,
  input  logic [smm_pkg::ACC_W-1:0] shift_in,
  output logic [smm_pkg::ACC_W-1:0] acc
);

  logic [smm_pkg::ACC_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= smm_pkg::ACC_W'(a) * smm_pkg::ACC_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (add_en) begin
      acc <= acc + prod;
    end else if (shift_en) begin
      acc <= shift_in;
    end
  end

endmodule

### rtl/sparse_matrix_multiply.sv
// top level: entry stores, walk sequencer and the chain of column cells
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------
//  command  | start, busy            | cmd (opcode, entry fields)
//  result   | result_valid (strobe)  | result (cell, found, is_last)
//  config   | cfg_we                 | cfg_index, cfg_data
//
// a load item leaves busy low; loads may come every cycle while no compute is running
// a compute item walks the rows: per row it issues the nk inner steps, drains
// the multiply pipeline and shifts out through the cell chain, then takes a final step
// a nonzero cell is held until the next one is found or the final step;
// the last result leaves the cycle after the final step; the receiver cannot stall
// reset sets each size to one and clears valid bits and control; stores read as zero after it
module sparse_matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  smm_pkg::cmd_t             cmd,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [smm_pkg::DIM_W-1:0] cfg_data,
  output logic                      result_valid,
  output smm_pkg::result_t          result
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [smm_pkg::DIM_W-1:0] MAX_D = smm_pkg::DIM_W'(MAX_DIM);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0] state;
  logic [smm_pkg::DIM_W-1:0] rows_of_a, inner_size, cols_of_b;
  logic [smm_pkg::DIM_W-1:0] nr, nk, nc;
  logic [IW-1:0] row_i, k_i, col_i, k_q;

  logic [MAX_DIM-1:0][smm_pkg::VAL_W-1:0] a_mem [MAX_DIM];
  logic [MAX_DIM-1:0][smm_pkg::VAL_W-1:0] b_mem [MAX_DIM];
  logic [MAX_DIM-1:0][MAX_DIM-1:0] a_ok, b_ok;
  logic [MAX_DIM-1:0][smm_pkg::VAL_W-1:0] a_row_q, b_row_q;
  logic [MAX_DIM-1:0] a_ok_q, b_ok_q;
  logic rd_v, mul_v;

  logic accept, load_ok, cand;
  logic [smm_pkg::VAL_W-1:0] a_bcast;
  logic [smm_pkg::ACC_W-1:0] acc [MAX_DIM];
  logic pend_v;
  smm_pkg::result_t pend;
  smm_pkg::result_t pend_last;

  assign nr = smm_pkg::clamp_dim(rows_of_a, MAX_D);
  assign nk = smm_pkg::clamp_dim(inner_size, MAX_D);
  assign nc = smm_pkg::clamp_dim(cols_of_b, MAX_D);

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign load_ok = (32'(cmd.entry_row) < MAX_DIM) && (32'(cmd.entry_col) < MAX_DIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_of_a  <= smm_pkg::DIM_W'(1);
      inner_size <= smm_pkg::DIM_W'(1);
      cols_of_b  <= smm_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        smm_pkg::REG_ROWS_OF_A:  rows_of_a  <= cfg_data;
        smm_pkg::REG_INNER_SIZE: inner_size <= cfg_data;
        smm_pkg::REG_COLS_OF_B:  cols_of_b  <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry stores, one row per word
  always_ff @(posedge clk) begin
    if (accept && load_ok && cmd.opcode == smm_pkg::OP_LOAD_A) begin
      a_mem[cmd.entry_row[IW-1:0]][cmd.entry_col[IW-1:0]] <= cmd.entry_value;
    end
    if (accept && load_ok && cmd.opcode == smm_pkg::OP_LOAD_B) begin
      b_mem[cmd.entry_row[IW-1:0]][cmd.entry_col[IW-1:0]] <= cmd.entry_value;
    end
    a_row_q <= a_mem[row_i];
    b_row_q <= b_mem[k_i];
  end

  always_ff @(posedge clk) begin
    if (rst || state == S_FINAL) begin
      a_ok <= '0;
      b_ok <= '0;
    end else if (accept && load_ok) begin
      if (cmd.opcode == smm_pkg::OP_LOAD_A) begin
        a_ok[cmd.entry_row[IW-1:0]][cmd.entry_col[IW-1:0]] <= 1'b1;
      end
      if (cmd.opcode == smm_pkg::OP_LOAD_B) begin
        b_ok[cmd.entry_row[IW-1:0]][cmd.entry_col[IW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_ok_q <= a_ok[row_i];
    b_ok_q <= b_ok[k_i];
    k_q    <= k_i;
  end

  assign a_bcast = a_ok_q[k_q] ? a_row_q[k_q] : '0;

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    smm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .mul_en   (rd_v),
      .add_en   (mul_v),
      .shift_en (state == S_SHIFT),
      .a        (a_bcast),
      .b        (b_ok_q[j] ? b_row_q[j] : '0),
      .shift_in ((j == MAX_DIM - 1) ? '0 : acc[(j + 1) % MAX_DIM]),
      .acc      (acc[j])
    );
  end

  assign cand = (state == S_SHIFT) && (4'(col_i) < nc) && (acc[0] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row_i <= '0;
      k_i   <= '0;
      col_i <= '0;
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= (state == S_MAC);
      mul_v <= rd_v;
      unique case (state)
        S_IDLE: begin
          row_i <= '0;
          k_i   <= '0;
          if (accept && cmd.opcode == smm_pkg::OP_COMPUTE) begin
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (4'(k_i) + 4'd1 == nk) begin
            k_i   <= '0;
            state <= S_DRAIN;
          end else begin
            k_i <= k_i + IW'(1);
          end
        end
        S_DRAIN: begin
          if (!rd_v && !mul_v) begin
            col_i <= '0;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          col_i <= col_i + IW'(1);
          if (32'(col_i) == MAX_DIM - 1) begin
            if (4'(row_i) + 4'd1 == nr) begin
              state <= S_FINAL;
            end else begin
              row_i <= row_i + IW'(1);
              state <= S_MAC;
            end
          end
        end
        S_FINAL: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // one nonzero cell is held back so the last can be flagged
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cand) begin
        pend_v       <= 1'b1;
        result_valid <= pend_v;
      end else if (state == S_FINAL) begin
        pend_v       <= 1'b0;
        result_valid <= 1'b1;
      end
    end
  end

  always_comb begin
    pend_last         = pend;
    pend_last.is_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cand) begin
      result           <= pend;
      pend.out_row     <= smm_pkg::IDX_W'(row_i);
      pend.out_col     <= smm_pkg::IDX_W'(col_i);
      pend.out_value   <= acc[0];
      pend.found       <= 1'b1;
      pend.is_last     <= 1'b0;
    end else if (state == S_FINAL) begin
      if (pend_v) begin
        result <= pend_last;
      end else begin
        result.out_row   <= '0;
        result.out_col   <= '0;
        result.out_value <= '0;
        result.found     <= 1'b0;
        result.is_last   <= 1'b1;
      end
    end
  end

  a_last_then_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_last |=> !result_valid)
    else $error("result after last item");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.is_last)
    else $error("marker not flagged last");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.found |-> result.out_value != '0)
    else $error("zero cell emitted");

  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_FINAL |=> state == S_IDLE && result_valid && result.is_last)
    else $error("final step did not close the compute");

endmodule
